>>> src/ksm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ksm_pkg;

    localparam int SLOTS      = 16;
    localparam int SLOT_W     = 4;
    localparam int CNT_W      = 5;
    localparam int KEY_W      = 64;
    localparam int STAMP_BITS = 32;
    localparam int CFG_W      = 5;

    localparam logic [CFG_W-1:0] OPEN_SLOTS_RST = CFG_W'(SLOTS);

    // controller to datapath
    typedef struct packed {
        logic load;       // capture the incoming request
        logic scan_init;  // clear scan index and match flag
        logic scan_step;  // examine one slot
        logic finish;     // update tables, load the result register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic last_hit;   // key equals the previous request's key
        logic scan_end;   // match found or all used slots examined
        logic out_free;   // result register can take a new result
    } t_stat;

endpackage
`default_nettype wire

>>> src/ksm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module ksm_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    input  ksm_pkg::t_stat    i_stat,
    output logic              o_in_ready,
    output ksm_pkg::t_cmd     o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOOK = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_cmd           = '0;
        o_in_ready      = 1'b0;
        case (r_state)
            S_IDLE: begin
                // refuse requests while reset is held
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_LOOK;
                end
            end
            S_LOOK: begin
                o_cmd.scan_init = 1'b1;
                n_state = i_stat.last_hit ? S_FIN : S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.scan_end) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                // hold until the result register is free
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

>>> src/ksm_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module ksm_dp (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  ksm_pkg::t_cmd                     i_cmd,
    output ksm_pkg::t_stat                    o_stat,
    input  wire  [ksm_pkg::KEY_W-1:0]         i_key,
    input  wire                               i_row_counted,
    input  wire                               i_cfg_valid,
    input  wire  [ksm_pkg::CFG_W-1:0]         i_cfg_data,
    input  wire                               i_out_ready,
    output logic                              o_out_valid,
    output logic [ksm_pkg::SLOT_W-1:0]        o_slot,
    output logic                              o_slot_new,
    output logic                              o_slot_evicted,
    output logic [ksm_pkg::KEY_W-1:0]         o_evicted_key
);

    logic [ksm_pkg::KEY_W-1:0]      r_slot_key   [ksm_pkg::SLOTS];
    logic [ksm_pkg::STAMP_BITS-1:0] r_slot_stamp [ksm_pkg::SLOTS];

    logic [ksm_pkg::CFG_W-1:0]      r_open_slots;
    logic [ksm_pkg::CNT_W-1:0]      r_used;
    logic [ksm_pkg::KEY_W-1:0]      r_last_key;
    logic [ksm_pkg::SLOT_W-1:0]     r_last_slot;
    logic                           r_last_valid;
    logic [ksm_pkg::STAMP_BITS-1:0] r_row_count;

    logic [ksm_pkg::KEY_W-1:0]      r_key;
    logic                           r_counted;
    logic [ksm_pkg::CNT_W-1:0]      r_idx;
    logic                           r_found;
    logic [ksm_pkg::SLOT_W-1:0]     r_match;
    logic [ksm_pkg::SLOT_W-1:0]     r_best_idx;
    logic [ksm_pkg::STAMP_BITS-1:0] r_best_stamp;
    logic [ksm_pkg::KEY_W-1:0]      r_best_key;

    logic [ksm_pkg::SLOT_W-1:0]     scan_addr;
    logic                           in_range;
    logic                           cur_hit;
    logic                           last_hit;
    logic                           out_free;
    logic [ksm_pkg::CNT_W-1:0]      limit;
    logic                           fresh;
    logic [ksm_pkg::SLOT_W-1:0]     f_slot;
    logic                           f_new;
    logic                           f_evict;
    logic [ksm_pkg::KEY_W-1:0]      f_old_key;

    assign scan_addr = r_idx[ksm_pkg::SLOT_W-1:0];
    assign in_range  = (r_idx < r_used);
    assign cur_hit   = in_range && (r_slot_key[scan_addr] == r_key);
    assign last_hit  = r_last_valid && (r_last_key == r_key);
    assign out_free  = !o_out_valid || i_out_ready;

    assign o_stat.last_hit = last_hit;
    assign o_stat.scan_end = !in_range || cur_hit;
    assign o_stat.out_free = out_free;

    // clamp the configured slot count into 1..SLOTS
    always_comb begin
        if (r_open_slots == '0) begin
            limit = ksm_pkg::CNT_W'(1);
        end else if (ksm_pkg::CNT_W'(r_open_slots) > ksm_pkg::CNT_W'(ksm_pkg::SLOTS)) begin
            limit = ksm_pkg::CNT_W'(ksm_pkg::SLOTS);
        end else begin
            limit = ksm_pkg::CNT_W'(r_open_slots);
        end
    end

    assign fresh = (r_used < limit);

    always_comb begin
        f_slot    = r_last_slot;
        f_new     = 1'b0;
        f_evict   = 1'b0;
        f_old_key = '0;
        if (!last_hit) begin
            if (r_found) begin
                f_slot = r_match;
            end else if (fresh) begin
                f_slot = r_used[ksm_pkg::SLOT_W-1:0];
                f_new  = 1'b1;
            end else begin
                f_slot    = r_best_idx;
                f_new     = 1'b1;
                f_evict   = 1'b1;
                f_old_key = r_best_key;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open_slots <= ksm_pkg::OPEN_SLOTS_RST;
            r_used       <= '0;
            r_last_slot  <= '0;
            r_last_valid <= 1'b0;
            r_row_count  <= '0;
            o_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_open_slots <= i_cfg_data;
            end
            if (o_out_valid && i_out_ready) begin
                o_out_valid <= 1'b0;
            end
            if (i_cmd.finish) begin
                o_out_valid <= 1'b1;
                if (!last_hit) begin
                    if (!r_found && fresh) begin
                        r_used <= r_used + ksm_pkg::CNT_W'(1);
                    end
                    r_last_slot  <= f_slot;
                    r_last_valid <= 1'b1;
                end
                // saturate the row count
                if (r_counted && (r_row_count != '1)) begin
                    r_row_count <= r_row_count + ksm_pkg::STAMP_BITS'(1);
                end
            end
        end
    end

    // payload: request, scan results, tables, result fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key     <= i_key;
            r_counted <= i_row_counted;
        end
        if (i_cmd.scan_init) begin
            r_idx   <= '0;
            r_found <= 1'b0;
        end
        if (i_cmd.scan_step && in_range && !cur_hit) begin
            // strict compare keeps the lowest index on ties
            if ((r_idx == '0) || (r_slot_stamp[scan_addr] < r_best_stamp)) begin
                r_best_stamp <= r_slot_stamp[scan_addr];
                r_best_idx   <= scan_addr;
                r_best_key   <= r_slot_key[scan_addr];
            end
            r_idx <= r_idx + ksm_pkg::CNT_W'(1);
        end
        if (i_cmd.scan_step && cur_hit) begin
            r_found <= 1'b1;
            r_match <= scan_addr;
        end
        if (i_cmd.finish) begin
            o_slot         <= f_slot;
            o_slot_new     <= f_new;
            o_slot_evicted <= f_evict;
            o_evicted_key  <= f_old_key;
            if (!last_hit) begin
                if (!r_found) begin
                    r_slot_key[f_slot] <= r_key;
                end
                r_slot_stamp[f_slot] <= r_row_count;
                r_last_key           <= r_key;
            end
        end
    end

endmodule
`default_nettype wire

>>> src/key_slot_map_lru_evict.sv
`timescale 1ns / 1ps
`default_nettype none
// Key to slot map with least-recently-dispatched eviction.
// Input stream: one request per row, 64-bit key in tdata, row_counted flag in
// tuser. Output stream: one result per request, in request order.
// Config channel: open_slots (5 bits), write only while the block is idle.
// A request equal to the previous key skips the scan; otherwise the scan walks
// the used slots one per cycle (key match and minimum stamp in one pass,
// stopping at a match). One request is in work at a time, so the next request
// is not accepted until the current one has finished.
// Reset: no slots used, no previous key, row count zero, open_slots = 16.
// Slot tables need no clearing; only used slots are read.
// Output stall: the result waits in an output register; the next request is
// still accepted and worked up to its table update, which holds until the
// output register is taken.
module key_slot_map_lru_evict (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [63:0] i_s_tdata,   // [63:0] key
    input  wire  [0:0]  i_s_tuser,   // [0] row_counted
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [71:0] o_m_tdata,   // [3:0] slot, [67:4] evicted_key, [71:68] zero
    output logic [1:0]  o_m_tuser,   // [0] slot_new, [1] slot_evicted
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [4:0]  i_cfg_data   // [4:0] open_slots
);

    ksm_pkg::t_cmd  cmd;
    ksm_pkg::t_stat stat;

    logic [ksm_pkg::SLOT_W-1:0] slot;
    logic                       slot_new;
    logic                       slot_evicted;
    logic [ksm_pkg::KEY_W-1:0]  evicted_key;

    // the register is writable whenever reset is released
    assign o_cfg_ready = i_rst_n;

    ksm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .i_stat     (stat),
        .o_in_ready (o_s_tready),
        .o_cmd      (cmd)
    );

    ksm_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_key          (i_s_tdata),
        .i_row_counted  (i_s_tuser[0]),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_data     (i_cfg_data),
        .i_out_ready    (i_m_tready),
        .o_out_valid    (o_m_tvalid),
        .o_slot         (slot),
        .o_slot_new     (slot_new),
        .o_slot_evicted (slot_evicted),
        .o_evicted_key  (evicted_key)
    );

    // pack result fields, lowest field first, pad to whole bytes
    assign o_m_tdata = {4'b0000, evicted_key, slot};
    assign o_m_tuser = {slot_evicted, slot_new};

endmodule
`default_nettype wire

>>> bench/key_slot_map_lru_evict_tb.sv
`timescale 1ns / 1ps
module key_slot_map_lru_evict_tb;
    import ksm_pkg::*;

    // One request on the slave side: key in tdata, row_counted in tuser.
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             counted;
    } t_row;

    // One dispatch decision on the master side.
    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              is_new;
        logic              evicted;
        logic [KEY_W-1:0]  old_key;
    } t_dispatch;

    localparam int ROWS_PER_PHASE = 75;
    localparam int SETTLE_CYCLES  = 25;   // a bit above the worst scan latency

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [KEY_W-1:0]  s_tdata   = '0;
    logic [0:0]        s_tuser   = '0;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [71:0]       m_tdata;
    logic [1:0]        m_tuser;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [CFG_W-1:0]  cfg_data  = '0;

    // Rows waiting for the driver, and dispatch decisions waiting for the block.
    t_row      pending_rows[$];
    t_dispatch dispatch_due[$];

    // Shadow copy of the slot map.
    logic [KEY_W-1:0]      map_key   [SLOTS];
    logic [STAMP_BITS-1:0] map_stamp [SLOTS];
    logic [CNT_W-1:0]      map_used  = '0;
    logic [KEY_W-1:0]      prev_key  = '0;
    logic [SLOT_W-1:0]     prev_slot = '0;
    logic                  prev_valid = 1'b0;
    logic [STAMP_BITS-1:0] row_total = '0;
    logic [CFG_W-1:0]      open_cfg  = OPEN_SLOTS_RST;

    int mismatches  = 0;
    int results_in  = 0;
    int n_fresh     = 0;
    int n_evict     = 0;
    int n_reuse     = 0;
    int n_settings  = 0;

    // Driver and receiver bookkeeping.
    logic s_took     = 1'b0;
    int   burst_left = 1;
    int   gap_left   = 0;
    int   hold_left  = 0;
    int   holds_done = 0;
    int   pat_mode   = 0;
    int   pat_left   = 0;

    // Stimulus side key pool.
    logic [KEY_W-1:0] key_pool[32];
    logic [KEY_W-1:0] last_queued = '0;

    key_slot_map_lru_evict i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_data (cfg_data)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    // Work out the dispatch of one request and advance the shadow map.
    function automatic t_dispatch dispatch_row(logic [KEY_W-1:0] key, logic counted);
        t_dispatch             r;
        int                    lim;
        int                    i;
        logic                  hit;
        logic [STAMP_BITS-1:0] best;
        r = '0;
        if (prev_valid && key == prev_key) begin
            r.slot = prev_slot;
        end else begin
            hit = 1'b0;
            for (i = 0; i < map_used && i < SLOTS; i++) begin
                if (!hit && map_key[i] == key) begin
                    r.slot = SLOT_W'(i);
                    hit    = 1'b1;
                end
            end
            if (!hit) begin
                r.is_new = 1'b1;
                // Clamp the open slot count into 1..SLOTS.
                lim = (open_cfg == 0) ? 1 : ((open_cfg > SLOTS) ? SLOTS : int'(open_cfg));
                if (map_used < lim) begin
                    r.slot   = map_used[SLOT_W-1:0];
                    map_used = map_used + CNT_W'(1);
                end else begin
                    // Evict the oldest stamp; strict compare keeps the lowest index on ties.
                    best   = map_stamp[0];
                    r.slot = '0;
                    for (i = 1; i < map_used && i < SLOTS; i++) begin
                        if (map_stamp[i] < best) begin
                            best   = map_stamp[i];
                            r.slot = SLOT_W'(i);
                        end
                    end
                    r.evicted = 1'b1;
                    r.old_key = map_key[r.slot];
                end
                map_key[r.slot] = key;
            end
            map_stamp[r.slot] = row_total;
            prev_key   = key;
            prev_slot  = r.slot;
            prev_valid = 1'b1;
        end
        // Saturate the row count at its maximum.
        if (counted && row_total != '1)
            row_total = row_total + STAMP_BITS'(1);
        return r;
    endfunction

    // Driver: present one request at a time, in bursts with gaps in between.
    always @(negedge clk) begin
        t_row row;
        logic busy;
        busy = s_tvalid && !s_took;
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!busy) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end else if (pending_rows.size() > 0) begin
                row = pending_rows.pop_front();
                s_tdata  <= row.key;
                s_tuser  <= row.counted;
                s_tvalid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 24);
                    // Often no gap at all, so long back-to-back stretches occur.
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: stall on a changing pattern, and twice hold off for a long
    // stretch so the block fills up and pushes back on its input.
    always @(negedge clk) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (holds_done < 2 && results_in >= 200 + 250 * holds_done) begin
            hold_left  <= 300;
            holds_done <= holds_done + 1;
            m_tready   <= 1'b0;
        end else begin
            if (pat_left == 0) begin
                pat_mode <= $urandom_range(0, 3);
                pat_left <= $urandom_range(8, 80);
            end else begin
                pat_left <= pat_left - 1;
            end
            case (pat_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 3) != 0);
                2: m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= ~m_tready;
            endcase
        end
    end

    // Monitor: track the config register, check each result against the oldest
    // expected dispatch, and predict each accepted request.
    always @(posedge clk) begin
        t_dispatch got;
        t_dispatch want;
        s_took <= s_tvalid && s_tready;
        if (rst_n) begin
            if (cfg_valid && cfg_ready)
                open_cfg = cfg_data;
            if (m_tvalid && m_tready) begin
                got.slot    = m_tdata[3:0];
                got.old_key = m_tdata[67:4];
                got.is_new  = m_tuser[0];
                got.evicted = m_tuser[1];
                results_in <= results_in + 1;
                if (dispatch_due.size() == 0) begin
                    $error("result with no request pending: slot %0d", got.slot);
                    mismatches++;
                end else begin
                    want = dispatch_due.pop_front();
                    if (got.slot !== want.slot) begin
                        $error("slot: expected %0d, got %0d", want.slot, got.slot);
                        mismatches++;
                    end
                    if (got.is_new !== want.is_new) begin
                        $error("slot_new: expected %0d, got %0d", want.is_new, got.is_new);
                        mismatches++;
                    end
                    if (got.evicted !== want.evicted) begin
                        $error("slot_evicted: expected %0d, got %0d",
                               want.evicted, got.evicted);
                        mismatches++;
                    end
                    if (got.old_key !== want.old_key) begin
                        $error("evicted_key: expected %h, got %h", want.old_key, got.old_key);
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                want = dispatch_row(s_tdata, s_tuser[0]);
                dispatch_due = {dispatch_due, want};
                if (want.evicted)
                    n_evict <= n_evict + 1;
                else if (want.is_new)
                    n_fresh <= n_fresh + 1;
                else
                    n_reuse <= n_reuse + 1;
            end
        end
    end

    // Queue one request for the driver.
    task automatic push_row(logic [KEY_W-1:0] key, logic counted);
        t_row row;
        row.key     = key;
        row.counted = counted;
        pending_rows = {pending_rows, row};
        last_queued = key;
    endtask

    // Hold until every request is dispatched and the block has gone quiet.
    task automatic wait_idle();
        while (pending_rows.size() != 0 || s_tvalid || dispatch_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_open_slots(logic [CFG_W-1:0] value);
        wait_idle();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid  <= 1'b0;
        n_settings = n_settings + 1;
    endtask

    // Queue random requests. Most keys come from a pool a little larger than the
    // slot limit, so hits, reuse of the previous key and evictions all happen.
    task automatic queue_random_rows(int count, int lim);
        int               pool_n;
        int               pick;
        int               n;
        int               bit_ix;
        logic [KEY_W-1:0] key;
        pool_n = lim + $urandom_range(0, 6);
        if (pool_n > 32)
            pool_n = 32;
        for (n = 0; n < count; n++) begin
            pick   = $urandom_range(0, 99);
            bit_ix = $urandom_range(0, KEY_W - 1);
            if (pick < 30)
                key = last_queued;
            else if (pick < 75)
                key = key_pool[$urandom_range(0, pool_n - 1)];
            else if (pick < 90)
                key = {$urandom, $urandom};
            else if (pick < 93)
                key = '0;
            else if (pick < 96)
                key = '1;
            else if (pick < 98)
                key = KEY_W'(1) << bit_ix;
            else
                key = ~(KEY_W'(1) << bit_ix);
            // Refresh a pool entry now and then so evicted keys vary.
            if ($urandom_range(0, 15) == 0)
                key_pool[$urandom_range(0, 31)] = {$urandom, $urandom};
            // Uncounted rows leave stamps equal, which exercises eviction ties.
            push_row(key, $urandom_range(0, 3) != 0);
        end
    endtask

    initial begin
        logic [CFG_W-1:0] settings[8];
        int               lim;
        int               p;
        for (p = 0; p < 32; p++)
            key_pool[p] = {$urandom, $urandom};
        settings = '{5'd16, 5'd1, 5'd4, 5'd31, 5'd0, 5'd9, 5'd2, 5'd16};
        settings[$urandom_range(1, 6)] = CFG_W'($urandom_range(0, 31));

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Two slots: key zero before any previous key exists, repeat of the
        // previous key, a hit in the first slot, a tie on equal stamps.
        set_open_slots(5'd2);
        push_row('0, 1'b0);
        push_row('0, 1'b0);
        push_row('1, 1'b0);
        push_row('0, 1'b1);
        push_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
        push_row('0, 1'b1);
        push_row('1, 1'b0);
        push_row(64'h5555_5555_5555_5555, 1'b1);

        // Lower the limit below the slots in use: every miss evicts.
        set_open_slots(5'd1);
        push_row(64'h8000_0000_0000_0001, 1'b1);
        push_row('0, 1'b1);
        push_row(64'h0123_4567_89AB_CDEF, 1'b0);
        push_row(64'h0123_4567_89AB_CDEF, 1'b1);

        // Zero acts as one.
        set_open_slots(5'd0);
        push_row(64'hFEDC_BA98_7654_3210, 1'b1);
        push_row(64'h1, 1'b1);
        push_row(64'h1, 1'b0);

        // Above the table size acts as the full table; fresh slots resume.
        set_open_slots(5'd31);
        push_row(64'h2, 1'b1);
        push_row(64'h4, 1'b1);
        push_row(64'hFFFF_FFFF_0000_0000, 1'b0);
        push_row('0, 1'b1);
        push_row(64'h2, 1'b1);
        push_row(64'h0000_0000_FFFF_FFFF, 1'b1);

        for (p = 0; p < 8; p++) begin
            set_open_slots(settings[p]);
            lim = (settings[p] == 0) ? 1 : ((settings[p] > SLOTS) ? SLOTS : int'(settings[p]));
            queue_random_rows(ROWS_PER_PHASE, lim);
        end

        wait_idle();
        repeat (40) @(posedge clk);
        $display("Dispatched %0d requests over %0d open_slots settings:", results_in, n_settings);
        $display("  %0d fresh slots, %0d evictions, %0d reuses", n_fresh, n_evict, n_reuse);
        if (mismatches == 0) begin
            $display("PASS key_slot_map_lru_evict");
        end else begin
            $display("FAIL key_slot_map_lru_evict");
        end
        $finish;
    end

    // Bound the run well past the slowest correct completion.
    initial begin
        #8_000_000;
        $display("FAIL key_slot_map_lru_evict");
        $finish;
    end

endmodule
